/* rtl/core/spt_pkg.sv */
// Shared constants and tables for the subsolar point pipeline.
package spt_pkg;

   // default number of CORDIC iterations
   localparam int CORDIC_STAGES = 24;

   // datapath widths
   localparam int ANG_W = 32;   // binary angle, 2^32 = 360 degrees
   localparam int TW    = 44;   // time since J2000 in ms
   localparam int CW    = 34;   // rotation CORDIC x/y/z, Q2.30 plus headroom
   localparam int VW    = 36;   // vectoring CORDIC x/y

   // J2000 epoch in ms since 1970
   localparam logic signed [TW-1:0] J2000_MS = 44'sd946728000000;

   // CORDIC gain compensation, Q30
   localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

   // rate angles: mean longitude, mean anomaly, sidereal angle
   localparam int IDX_ML = 0;
   localparam int IDX_MA = 1;
   localparam int IDX_ST = 2;
   localparam int N_RATE = 3;

   localparam logic [ANG_W-1:0] BASE_TAB [N_RATE] = '{
      32'd3346018133, 32'd4265475187, 32'd3346025510
   };
   localparam logic signed [38:0] RATE_TAB [N_RATE] = '{
      39'sd584554570, 39'sd584526636, 39'sd214088536884
   };

   // obliquity: base and negated rate
   localparam logic [ANG_W-1:0]   EPS_BASE     = 32'd279638162;
   localparam logic signed [9:0]  EPS_RATE_NEG = -10'sd237;

   // equation of centre terms in binary angle units, applied to Q30 sines
   localparam logic signed [25:0] EOC_1 = 26'sd22846840;
   localparam logic signed [18:0] EOC_2 = 19'sd238609;

   // arctangent table in binary angle units
   localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

/* rtl/core/spt_cordic_rot.sv */
// Pipelined rotation CORDIC: cosine and sine of a binary angle, Q2.30.
module spt_cordic_rot #(
   parameter int STAGES = spt_pkg::CORDIC_STAGES
) (
   input  logic                           clock,
   input  logic [spt_pkg::ANG_W-1:0]      angle,
   output logic signed [spt_pkg::CW-1:0]  cos_out,
   output logic signed [spt_pkg::CW-1:0]  sin_out
);

   localparam int CW = spt_pkg::CW;
   localparam logic signed [CW-1:0] QUARTER = 34'sh040000000;
   localparam logic signed [CW-1:0] HALF    = 34'sh080000000;
   localparam logic signed [CW-1:0] X_START = CW'(spt_pkg::INV_GAIN);

   logic signed [CW-1:0] x_ff [STAGES+1];
   logic signed [CW-1:0] y_ff [STAGES+1];
   logic signed [CW-1:0] z_ff [STAGES+1];
   logic                 flip_ff [STAGES+1];
   logic signed [CW-1:0] z_in;
   logic                 flip_in;
   logic signed [CW-1:0] cos_ff;
   logic signed [CW-1:0] sin_ff;

   // fold the angle into +/- 90 degrees
   always_comb begin
      z_in    = CW'($signed(angle));
      flip_in = 1'b0;
      if (z_in > QUARTER) begin
         z_in    = z_in - HALF;
         flip_in = 1'b1;
      end else if (z_in < -QUARTER) begin
         z_in    = z_in + HALF;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= X_START;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [CW-1:0] ATAN =
         $signed({{(CW-spt_pkg::ANG_W){1'b0}}, spt_pkg::ATAN_TAB[i]});
      always_ff @(posedge clock) begin
         flip_ff[i+1] <= flip_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ATAN;
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ATAN;
         end
      end
   end

   // undo the fold
   always_ff @(posedge clock) begin
      cos_ff <= flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      sin_ff <= flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

/* rtl/core/spt_cordic_vec.sv */
// Pipelined vectoring CORDIC: binary angle and gain-corrected magnitude.
module spt_cordic_vec #(
   parameter int STAGES = spt_pkg::CORDIC_STAGES
) (
   input  logic                           clock,
   input  logic signed [spt_pkg::VW-1:0]  vx,
   input  logic signed [spt_pkg::VW-1:0]  vy,
   output logic [spt_pkg::ANG_W-1:0]      angle,
   output logic signed [spt_pkg::VW-1:0]  mag
);

   localparam int VW = spt_pkg::VW;
   localparam int AW = spt_pkg::ANG_W;
   localparam int PW = VW + 32;

   logic signed [VW-1:0] x_ff [STAGES+1];
   logic signed [VW-1:0] y_ff [STAGES+1];
   logic [AW-1:0]        acc_ff [STAGES+1];
   logic signed [PW-1:0] prod_ff;
   logic [AW-1:0]        acc_m_ff;
   logic signed [VW-1:0] mag_ff;
   logic [AW-1:0]        angle_ff;

   // move the vector into the right half plane
   always_ff @(posedge clock) begin
      if (vx < 0) begin
         x_ff[0]   <= -vx;
         y_ff[0]   <= -vy;
         acc_ff[0] <= 32'h8000_0000;
      end else begin
         x_ff[0]   <= vx;
         y_ff[0]   <= vy;
         acc_ff[0] <= '0;
      end
   end

   // drive y toward zero, one stage per iteration
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (y_ff[i] >= 0) begin
            x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
            acc_ff[i+1] <= acc_ff[i] + spt_pkg::ATAN_TAB[i];
         end else begin
            x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
            acc_ff[i+1] <= acc_ff[i] - spt_pkg::ATAN_TAB[i];
         end
      end
   end

   // gain correction: multiply, then round
   always_ff @(posedge clock) begin
      prod_ff  <= x_ff[STAGES] * spt_pkg::INV_GAIN;
      acc_m_ff <= acc_ff[STAGES];
      mag_ff   <= VW'((prod_ff + PW'(2**29)) >>> 30);
      angle_ff <= acc_m_ff;
   end

   assign angle = angle_ff;
   assign mag   = mag_ff;

endmodule

/* rtl/core/subsolar_point_from_time.sv */
// Subsolar point (latitude, longitude, sun direction) from a UTC time stamp.
// Throughput: one transaction per cycle; busy is never raised.
// Latency is set by the five CORDIC passes in series (three rotation, two vectoring).
// Synchronous active-high reset clears the valid pipeline only; no clearing pass.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall them.
module subsolar_point_from_time #(
   parameter int CORDIC_STAGES = spt_pkg::CORDIC_STAGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [42:0] req_utc_ms,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_latitude_deg,
   output logic signed [24:0] rsp_longitude_deg,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z
);

   localparam int AW    = spt_pkg::ANG_W;
   localparam int TW    = spt_pkg::TW;
   localparam int CW    = spt_pkg::CW;
   localparam int VW    = spt_pkg::VW;
   localparam int PW    = 2 * CW;
   localparam int EW1   = 26 + CW;
   localparam int EW2   = 19 + CW;
   localparam int DMW   = 40;
   localparam int LR    = CORDIC_STAGES + 2;
   localparam int LV    = CORDIC_STAGES + 3;
   localparam int TOTAL = 9 + 3 * LR + 2 * LV;
   localparam int DL_EPS = LR + 2;
   localparam int DL_GST = LR + 2 + LR + 2 + LV;
   localparam logic signed [7:0]    DEG_MUL  = 8'sd45;
   localparam logic signed [VW-1:0] Q14_MAX  = VW'(16384);

   // round v / 2^16 and clamp to the Q2.14 unit range
   function automatic logic [15:0] to_q14(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] r;
      r = (v + VW'(2**15)) >>> 16;
      if (r > Q14_MAX) begin
         r = Q14_MAX;
      end else if (r < -Q14_MAX) begin
         r = -Q14_MAX;
      end
      return r[15:0];
   endfunction

   logic                    req_acc;
   logic [TOTAL-1:0]        vld_ff;

   // time and rate angles
   logic signed [TW-1:0]    t_in;
   logic signed [TW-1:0]    t_ff;
   logic signed [21:0]      t_hi;
   logic signed [22:0]      t_lo;
   logic [spt_pkg::N_RATE-1:0][41:0] ph_ff;
   logic [spt_pkg::N_RATE-1:0][59:0] pl_ff;
   logic [spt_pkg::N_RATE-1:0][AW-1:0] ang_ff;
   logic [AW-1:0]           eps_hi_ff;
   logic [AW-1:0]           eps_ff;
   logic signed [63:0]      eps_prod;

   // CORDIC results
   logic signed [CW-1:0]    sg, s2g, ce, se, cl, sl, clo, slo, cd, sd;

   // equation of centre
   logic [LR-1:0][AW-1:0]   ml_dly_ff;
   logic signed [EW1-1:0]   eoc1_ff;
   logic signed [EW2-1:0]   eoc2_ff;
   logic [AW-1:0]           ml_c_ff;
   logic signed [EW1-1:0]   eoc1_r;
   logic signed [EW2-1:0]   eoc2_r;
   logic [AW-1:0]           lam_ff;

   // equatorial vector
   logic [DL_EPS-1:0][2*CW-1:0] cse_dly_ff;
   logic signed [CW-1:0]    ce_d, se_d;
   logic signed [PW-1:0]    py_ff, pz_ff;
   logic signed [CW-1:0]    xe_ff;
   logic signed [VW-1:0]    vx_ff, vy_ff, vz_ff;

   // angles back out
   logic [AW-1:0]           ra;
   logic signed [VW-1:0]    rmag;
   logic [LV-1:0][VW-1:0]   z_dly_ff;
   logic [AW-1:0]           dec;
   logic [DL_GST-1:0][AW-1:0] gst_dly_ff;
   logic [AW-1:0]           lon_in;
   logic [LV-1:0][AW-1:0]   lon_dly_ff;
   logic [LR-1:0][2*AW-1:0] dl_dly_ff;

   // output stages
   logic signed [PW-1:0]    pox_ff, poy_ff;
   logic signed [CW-1:0]    sd_ff;
   logic signed [DMW-1:0]   latm_ff, lonm_ff;
   logic signed [DMW-1:0]   lat_r, lon_r;
   logic signed [VW-1:0]    dx_r, dy_r;
   logic signed [23:0]      lat_ff;
   logic signed [24:0]      lon_ff;
   logic [15:0]             dx_ff, dy_ff, dz_ff;

   assign busy    = 1'b0;
   assign req_acc = start & ~busy;

   // valid bits follow each transaction through every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[TOTAL-2:0], req_acc};
      end
   end

   // stage 1: time since J2000
   assign t_in = TW'(req_utc_ms) - spt_pkg::J2000_MS;

   always_ff @(posedge clock) begin
      t_ff <= t_in;
   end

   // stage 2: rate products in two halves of the time word
   assign t_hi     = t_ff[TW-1:22];
   assign t_lo     = {1'b0, t_ff[21:0]};
   assign eps_prod = 64'(spt_pkg::EPS_RATE_NEG * t_ff);

   for (genvar k = 0; k < spt_pkg::N_RATE; k++) begin : g_rate
      always_ff @(posedge clock) begin
         ph_ff[k] <= 42'(spt_pkg::RATE_TAB[k] * t_hi);
         pl_ff[k] <= 60'(spt_pkg::RATE_TAB[k] * t_lo);
      end
      // stage 3: merge halves, keep the angle word, add base
      always_ff @(posedge clock) begin
         ang_ff[k] <= spt_pkg::BASE_TAB[k]
                    + 32'(({ph_ff[k], 22'b0} + {4'b0, pl_ff[k]}) >> 32);
      end
   end

   always_ff @(posedge clock) begin
      eps_hi_ff <= eps_prod[63:32];
      eps_ff    <= spt_pkg::EPS_BASE + eps_hi_ff;
   end

   // sin g, sin 2g, and cos/sin of obliquity
   spt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_g (
      .clock(clock), .angle(ang_ff[spt_pkg::IDX_MA]), .cos_out(), .sin_out(sg)
   );
   spt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_g2 (
      .clock(clock), .angle({ang_ff[spt_pkg::IDX_MA][AW-2:0], 1'b0}),
      .cos_out(), .sin_out(s2g)
   );
   spt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_eps (
      .clock(clock), .angle(eps_ff), .cos_out(ce), .sin_out(se)
   );

   // ecliptic longitude: mean longitude plus two-term equation of centre
   assign eoc1_r = (eoc1_ff + EW1'(2**29)) >>> 30;
   assign eoc2_r = (eoc2_ff + EW2'(2**29)) >>> 30;

   always_ff @(posedge clock) begin
      ml_dly_ff <= {ml_dly_ff[LR-2:0], ang_ff[spt_pkg::IDX_ML]};
      eoc1_ff   <= spt_pkg::EOC_1 * sg;
      eoc2_ff   <= spt_pkg::EOC_2 * s2g;
      ml_c_ff   <= ml_dly_ff[LR-1];
      lam_ff    <= ml_c_ff + eoc1_r[AW-1:0] + eoc2_r[AW-1:0];
   end

   spt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lam (
      .clock(clock), .angle(lam_ff), .cos_out(cl), .sin_out(sl)
   );

   // tilt by obliquity into the equatorial frame
   assign ce_d = cse_dly_ff[DL_EPS-1][2*CW-1:CW];
   assign se_d = cse_dly_ff[DL_EPS-1][CW-1:0];

   always_ff @(posedge clock) begin
      cse_dly_ff <= {cse_dly_ff[DL_EPS-2:0], ce, se};
      py_ff      <= ce_d * sl;
      pz_ff      <= se_d * sl;
      xe_ff      <= cl;
      vx_ff      <= VW'(xe_ff);
      vy_ff      <= VW'((py_ff + PW'(2**29)) >>> 30);
      vz_ff      <= VW'((pz_ff + PW'(2**29)) >>> 30);
   end

   // right ascension and xy magnitude
   spt_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec_ra (
      .clock(clock), .vx(vx_ff), .vy(vy_ff), .angle(ra), .mag(rmag)
   );

   always_ff @(posedge clock) begin
      z_dly_ff <= {z_dly_ff[LV-2:0], vz_ff};
   end

   // declination
   spt_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec_dec (
      .clock(clock), .vx(rmag), .vy($signed(z_dly_ff[LV-1])), .angle(dec), .mag()
   );

   // subsolar longitude: right ascension minus sidereal angle
   assign lon_in = ra - gst_dly_ff[DL_GST-1];

   always_ff @(posedge clock) begin
      gst_dly_ff <= {gst_dly_ff[DL_GST-2:0], ang_ff[spt_pkg::IDX_ST]};
      lon_dly_ff <= {lon_dly_ff[LV-2:0], lon_in};
      dl_dly_ff  <= {dl_dly_ff[LR-2:0], dec, lon_dly_ff[LV-1]};
   end

   spt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lon (
      .clock(clock), .angle(lon_dly_ff[LV-1]), .cos_out(clo), .sin_out(slo)
   );
   spt_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dec (
      .clock(clock), .angle(dec), .cos_out(cd), .sin_out(sd)
   );

   // output stage 1: direction products and degree scaling
   always_ff @(posedge clock) begin
      pox_ff  <= cd * clo;
      poy_ff  <= cd * slo;
      sd_ff   <= sd;
      latm_ff <= $signed(dl_dly_ff[LR-1][2*AW-1:AW]) * DEG_MUL;
      lonm_ff <= $signed(dl_dly_ff[LR-1][AW-1:0]) * DEG_MUL;
   end

   // output stage 2: rounding and saturation
   assign lat_r = (latm_ff + DMW'(4096)) >>> 13;
   assign lon_r = (lonm_ff + DMW'(4096)) >>> 13;
   assign dx_r  = VW'((pox_ff + PW'(2**29)) >>> 30);
   assign dy_r  = VW'((poy_ff + PW'(2**29)) >>> 30);

   always_ff @(posedge clock) begin
      lat_ff <= lat_r[23:0];
      lon_ff <= lon_r[24:0];
      dx_ff  <= to_q14(dx_r);
      dy_ff  <= to_q14(dy_r);
      dz_ff  <= to_q14(VW'(sd_ff));
   end

   assign rsp_valid         = vld_ff[TOTAL-1];
   assign rsp_latitude_deg  = lat_ff;
   assign rsp_longitude_deg = lon_ff;
   assign rsp_dir_x         = dx_ff;
   assign rsp_dir_y         = dy_ff;
   assign rsp_dir_z         = dz_ff;

   // every result traces back to an accepted transaction
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_acc, TOTAL))
      else $error("result without matching transaction");

   // latitude stays within +/-90 degrees
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_latitude_deg <= 24'sd5898240 &&
                     rsp_latitude_deg >= -24'sd5898240))
      else $error("latitude out of range");

   // z component saturation bound
   a_dirz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dir_z <= 16'sd16384 && rsp_dir_z >= -16'sd16384))
      else $error("dir_z out of range");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the subsolar point pipeline.
module testbench;

   localparam int STAGES = spt_pkg::CORDIC_STAGES;
   localparam int LATENCY = 5 * STAGES + 21;
   localparam longint CYCLE_LIMIT = 400000;

   // one expected subsolar result
   typedef struct {
      logic signed [23:0] lat;
      logic signed [24:0] lon;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [15:0] dz;
   } sun_point_type;

   // arithmetic shift with floor
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   // round half up
   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint angle_signed(logic [31:0] a);
      return longint'($signed(a));
   endfunction

   function automatic logic [31:0] rate_angle(logic [31:0] base, logic [63:0] k,
                                              longint t);
      logic [63:0] p;
      p = k * 64'(t);
      return base + p[63:32];
   endfunction

   // rotation CORDIC: cosine and sine of a binary angle, Q2.30
   function automatic void rotate_angle(input logic [31:0] a, output longint c,
                                        output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = angle_signed(a);
      x = spt_pkg::INV_GAIN;
      y = 0;
      flip = 0;
      if (z > 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = shr_floor(x, i);
         dy = shr_floor(y, i);
         if (z >= 0) begin
            x -= dy; y += dx; z -= longint'(spt_pkg::ATAN_TAB[i]);
         end else begin
            x += dy; y -= dx; z += longint'(spt_pkg::ATAN_TAB[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // vectoring CORDIC: angle and magnitude of (x, y)
   function automatic void vector_angle(input longint xi, input longint yi,
                                        output logic [31:0] acc, output longint mag);
      longint x, y, dx, dy;
      x = xi;
      y = yi;
      acc = 0;
      if (x < 0) begin
         x = -x; y = -y; acc = 32'h80000000;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = shr_floor(x, i);
         dy = shr_floor(y, i);
         if (y >= 0) begin
            x += dy; y -= dx; acc += spt_pkg::ATAN_TAB[i];
         end else begin
            x -= dy; y += dx; acc -= spt_pkg::ATAN_TAB[i];
         end
      end
      mag = round_shr(x * longint'(spt_pkg::INV_GAIN), 30);
   endfunction

   function automatic logic [15:0] to_q14(longint v);
      longint r;
      r = round_shr(v, 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   // full subsolar point computation for one time stamp
   function automatic void predict_sun_point(input logic signed [42:0] utc,
                                             output sun_point_type p);
      longint t, cg, sg, c2g, s2g, cl, sl, ce, se, y, z, r, spare;
      longint clo, slo, cd, sd, ld, od;
      logic [31:0] ml, ma, eps, gst, lam, ra, dec, lon;
      t = longint'(utc) - 64'sd946728000000;
      ml = rate_angle(spt_pkg::BASE_TAB[spt_pkg::IDX_ML],
                      64'(spt_pkg::RATE_TAB[spt_pkg::IDX_ML]), t);
      ma = rate_angle(spt_pkg::BASE_TAB[spt_pkg::IDX_MA],
                      64'(spt_pkg::RATE_TAB[spt_pkg::IDX_MA]), t);
      eps = rate_angle(spt_pkg::EPS_BASE, 64'(longint'(spt_pkg::EPS_RATE_NEG)), t);
      gst = rate_angle(spt_pkg::BASE_TAB[spt_pkg::IDX_ST],
                       64'(spt_pkg::RATE_TAB[spt_pkg::IDX_ST]), t);
      rotate_angle(ma, cg, sg);
      rotate_angle(ma << 1, c2g, s2g);
      lam = ml + 32'(round_shr(longint'(spt_pkg::EOC_1) * sg, 30))
               + 32'(round_shr(longint'(spt_pkg::EOC_2) * s2g, 30));
      rotate_angle(lam, cl, sl);
      rotate_angle(eps, ce, se);
      y = round_shr(ce * sl, 30);
      z = round_shr(se * sl, 30);
      vector_angle(cl, y, ra, r);
      vector_angle(r, z, dec, spare);
      lon = ra - gst;
      rotate_angle(lon, clo, slo);
      rotate_angle(dec, cd, sd);
      ld = round_shr(angle_signed(dec) * 45, 13);
      od = round_shr(angle_signed(lon) * 45, 13);
      p.lat = ld[23:0];
      p.lon = od[24:0];
      p.dx = to_q14(round_shr(cd * clo, 30));
      p.dy = to_q14(round_shr(cd * slo, 30));
      p.dz = to_q14(sd);
   endfunction

   // in-order store of expected points
   class sun_point_board;
      sun_point_type pending[$];
      int errors;

      function void note_time(logic signed [42:0] utc);
         sun_point_type p;
         predict_sun_point(utc, p);
         pending.push_back(p);
      endfunction

      function void check_point(sun_point_type got);
         sun_point_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result lat=%0d", $time, got.lat);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.lat !== want.lat) begin
            $display("%0t: latitude exp %0d got %0d", $time, want.lat, got.lat);
            errors++;
         end
         if (got.lon !== want.lon) begin
            $display("%0t: longitude exp %0d got %0d", $time, want.lon, got.lon);
            errors++;
         end
         if (got.dx !== want.dx) begin
            $display("%0t: dir_x exp %0d got %0d", $time, want.dx, got.dx);
            errors++;
         end
         if (got.dy !== want.dy) begin
            $display("%0t: dir_y exp %0d got %0d", $time, want.dy, got.dy);
            errors++;
         end
         if (got.dz !== want.dz) begin
            $display("%0t: dir_z exp %0d got %0d", $time, want.dz, got.dz);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [42:0] req_utc_ms = '0;
   logic rsp_valid;
   logic signed [23:0] rsp_latitude_deg;
   logic signed [24:0] rsp_longitude_deg;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;

   sun_point_board board = new();
   longint cycles = 0;
   int idle_pct = 0;

   subsolar_point_from_time u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      sun_point_type got;
      if (!reset && rsp_valid) begin
         got.lat = rsp_latitude_deg;
         got.lon = rsp_longitude_deg;
         got.dx = rsp_dir_x;
         got.dy = rsp_dir_y;
         got.dz = rsp_dir_z;
         board.check_point(got);
      end
   end

   // issue one transaction, with random idle cycles before it
   task automatic send_time(logic signed [42:0] utc);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_utc_ms <= utc;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_time(utc);
   endtask

   // random stamp: half from 1970 to about 2033, a quarter near J2000, a quarter over the full range
   function automatic logic signed [42:0] random_time();
      logic [42:0] v;
      case ($urandom_range(3, 0))
         0: v = 43'({$urandom(), $urandom()});
         1: v = 43'(64'sd946728000000 + longint'($signed($urandom())) * 4);
         default: v = 43'(longint'($urandom_range(32'd2000000, 0)) * 64'd1000000);
      endcase
      return v;
   endfunction

   task automatic drain_results();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic signed [42:0] directed[$];
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: range limits, epoch, J2000, solstices and equinoxes
      directed = '{43'sh40000000000, 43'sh3FFFFFFFFFF, 0, -1, 1,
                   43'sd946728000000, 43'sd946727999999, 43'sd953640000000,
                   43'sd961560000000, 43'sd969580000000, 43'sd977400000000,
                   43'sh2AAAAAAAAAA, 43'sh55555555555, 43'sd1700000000000,
                   43'sd1718900000000, -43'sd946728000000};
      foreach (directed[i]) send_time(directed[i]);
      // walk one day for the longitude seam
      for (int h = 0; h < 8; h++) send_time(43'sd1700000000000 + h * 43'sd10800000);
      drain_results();

      // random phases with different sender idling
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 0) ? 0 : (ph == 1) ? 84 : (ph == 2) ? 0 : 32;
         for (int n = 0; n < 350; n++) send_time(random_time());
         if (ph == 1) drain_results();
      end
      start <= 0;

      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/core/spt_pkg.sv
rtl/core/spt_cordic_rot.sv
rtl/core/spt_cordic_vec.sv
rtl/core/subsolar_point_from_time.sv
sim/testbench.sv
